// File: hw/rtl/s3rx_pkg.sv
// Package for the SIMD three-register extension decoder.
// Holds instruction ids, arrangement codes, rotation constants and the key lookup.
// No dependencies.
package s3rx_pkg;

    // Instruction identities, numbered densely in order of first appearance.
    localparam logic [4:0] ID_SDOT     = 5'd0;
    localparam logic [4:0] ID_FCVTN    = 5'd1;
    localparam logic [4:0] ID_FCVTN2   = 5'd2;
    localparam logic [4:0] ID_FDOT     = 5'd3;
    localparam logic [4:0] ID_USDOT    = 5'd4;
    localparam logic [4:0] ID_SQRDMLAH = 5'd5;
    localparam logic [4:0] ID_SQRDMLSH = 5'd6;
    localparam logic [4:0] ID_UDOT     = 5'd7;
    localparam logic [4:0] ID_FCMLA    = 5'd8;
    localparam logic [4:0] ID_FCADD    = 5'd9;
    localparam logic [4:0] ID_BFDOT    = 5'd10;
    localparam logic [4:0] ID_BFMLALB  = 5'd11;
    localparam logic [4:0] ID_BFMLALT  = 5'd12;
    localparam logic [4:0] ID_FMLALLBB = 5'd13;
    localparam logic [4:0] ID_FMLALLBT = 5'd14;
    localparam logic [4:0] ID_FMLALB   = 5'd15;
    localparam logic [4:0] ID_FMLALLTB = 5'd16;
    localparam logic [4:0] ID_FMLALLTT = 5'd17;
    localparam logic [4:0] ID_SMMLA    = 5'd18;
    localparam logic [4:0] ID_USMMLA   = 5'd19;
    localparam logic [4:0] ID_FMLALT   = 5'd20;
    localparam logic [4:0] ID_FMMLA    = 5'd21;
    localparam logic [4:0] ID_BFMMLA   = 5'd22;
    localparam logic [4:0] ID_UMMLA    = 5'd23;
    localparam logic [4:0] ID_LAST     = ID_UMMLA;

    // Arrangement specifier codes.
    localparam logic [2:0] ARR_8B  = 3'd0;
    localparam logic [2:0] ARR_16B = 3'd1;
    localparam logic [2:0] ARR_4H  = 3'd2;
    localparam logic [2:0] ARR_8H  = 3'd3;
    localparam logic [2:0] ARR_2S  = 3'd4;
    localparam logic [2:0] ARR_4S  = 3'd5;

    // Rotation immediates in degrees.
    localparam logic [8:0] ROT_0   = 9'd0;
    localparam logic [8:0] ROT_90  = 9'd90;
    localparam logic [8:0] ROT_180 = 9'd180;
    localparam logic [8:0] ROT_270 = 9'd270;

    typedef struct packed {
        logic       hit;
        logic [4:0] id;
    } t_key_hit;

    // Fixed key table: Q:U:size:opcode after masking, to instruction id.
    function automatic t_key_hit lookup_key(input logic [7:0] key);
        t_key_hit res;
        res.hit = 1'b1;
        res.id  = ID_SDOT;
        case (key)
            8'h02, 8'h82: res.id = ID_SDOT;
            8'h0E:        res.id = ID_FCVTN;
            8'h8E:        res.id = ID_FCVTN2;
            8'h0F, 8'h8F: res.id = ID_FDOT;
            8'h1E, 8'h9E: res.id = ID_FCVTN;
            8'h1F, 8'h9F: res.id = ID_FDOT;
            8'h23, 8'hA3: res.id = ID_USDOT;
            8'h40, 8'hC0: res.id = ID_SQRDMLAH;
            8'h41, 8'hC1: res.id = ID_SQRDMLSH;
            8'h42, 8'hC2: res.id = ID_UDOT;
            8'h48, 8'hC8: res.id = ID_FCMLA;
            8'h4C, 8'hCC: res.id = ID_FCADD;
            8'h5F, 8'hDF: res.id = ID_BFDOT;
            8'h7F:        res.id = ID_BFMLALB;
            8'hFF:        res.id = ID_BFMLALT;
            8'h08:        res.id = ID_FMLALLBB;
            8'h18:        res.id = ID_FMLALLBT;
            8'h3F:        res.id = ID_FMLALB;
            8'h88:        res.id = ID_FMLALLTB;
            8'h98:        res.id = ID_FMLALLTT;
            8'hA4:        res.id = ID_SMMLA;
            8'hA5:        res.id = ID_USMMLA;
            8'hBF:        res.id = ID_FMLALT;
            8'hCD, 8'hED: res.id = ID_FMMLA;
            8'hDD:        res.id = ID_BFMMLA;
            8'hE4:        res.id = ID_UMMLA;
            default:      res.hit = 1'b0;
        endcase
        return res;
    endfunction

endpackage

// File: hw/rtl/simd_three_reg_ext_decoder.sv
// Top level of the SIMD three-register extension decoder.
// Depends on s3rx_pkg for ids, arrangement codes and the key lookup.
// Decodes one 32-bit instruction word per request into an instruction id, the
// register numbers Rd/Rn/Rm, three arrangement codes and an optional rotation.
// A request is captured in an input register, decoded by one pass of logic and
// written to a result register when that register is free or being emptied. One
// instruction is accepted every cycle while the consumer keeps up; while a
// finished result waits, the input register takes one more request and then
// holds o_ready low until the result is taken. Fixed encoding bits are not
// checked. On an error every field other than o_decode_error reads zero.
module simd_three_reg_ext_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_instruction_word,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_decode_error,
    output logic [4:0]  o_insn_id,
    output logic [4:0]  o_dest_index,
    output logic [4:0]  o_src_a_index,
    output logic [4:0]  o_src_b_index,
    output logic [2:0]  o_dest_arrangement,
    output logic [2:0]  o_src_a_arrangement,
    output logic [2:0]  o_src_b_arrangement,
    output logic        o_has_rotation,
    output logic [8:0]  o_rotation_degrees
);
    import s3rx_pkg::*;

    logic        r_s1_valid;
    logic [31:0] r_s1_word;
    logic        r_out_valid;
    logic        r_err, r_hasrot;
    logic [4:0]  r_id, r_rd, r_rn, r_rm;
    logic [2:0]  r_ad, r_aa, r_ab;
    logic [8:0]  r_rot;

    logic        s1_ready, out_ready;
    logic        q, u;
    logic [1:0]  size;
    logic [3:0]  op;
    logic [2:0]  bits;
    logic [7:0]  key;
    t_key_hit    hit;
    logic        n_err, n_hasrot;
    logic [2:0]  n_ad, n_aa, n_ab;
    logic [8:0]  n_rot;

    // Pipeline flow control: each stage moves when the one after it can take.
    assign out_ready = !r_out_valid || i_ready;
    assign s1_ready  = !r_s1_valid || out_ready;
    assign o_ready   = s1_ready;

    // Field extraction and key masking.
    always_comb begin
        q    = r_s1_word[30];
        u    = r_s1_word[29];
        size = r_s1_word[23:22];
        op   = r_s1_word[14:11];
        bits = {size, q};
        key  = {q, u, size, op};
        if (op <= 4'd2) begin
            key[5:4] = 2'b00;
        end
        if (u && op[3:2] == 2'b10) begin
            key[5:4] = 2'b00;
            key[1:0] = 2'b00;
        end else if (u && op[3:2] == 2'b11 && !op[0]) begin
            key[5:4] = 2'b00;
            key[1]   = 1'b0;
        end
        hit = lookup_key(key);
    end

    // Arrangement and rotation rules, first match wins.
    always_comb begin
        n_err    = 1'b0;
        n_ad     = ARR_8B;
        n_aa     = ARR_8B;
        n_ab     = ARR_8B;
        n_hasrot = 1'b0;
        n_rot    = ROT_0;
        if (!hit.hit) begin
            n_err = 1'b1;
        end else if (op == 4'd14) begin
            n_ad = {2'b00, q};
            n_aa = (size == 2'd0) ? ARR_4S : {2'b01, q};
            n_ab = n_aa;
        end else if (!u && !size[1] && op == 4'd15) begin
            n_ad = (size == 2'd0) ? {2'b10, q} : {2'b01, q};
            n_aa = {2'b00, q};
            n_ab = {2'b00, q};
        end else if (op[3:2] == 2'b01 || op == 4'd2 || op == 4'd3) begin
            n_ad = {2'b10, q};
            n_aa = {2'b00, q};
            n_ab = {2'b00, q};
        end else if (u && op <= 4'd1) begin
            n_err = (bits < 3'd2) || (bits > 3'd5);
            n_ad  = bits;
            n_aa  = bits;
            n_ab  = bits;
        end else if (u && (op[3:2] == 2'b10 || op == 4'd12)) begin
            n_err    = (bits < 3'd2);
            n_ad     = bits;
            n_aa     = bits;
            n_ab     = bits;
            n_hasrot = 1'b1;
            if (op[3:2] == 2'b10) begin
                case (op[1:0])
                    2'd0:    n_rot = ROT_0;
                    2'd1:    n_rot = ROT_90;
                    2'd2:    n_rot = ROT_180;
                    default: n_rot = ROT_270;
                endcase
            end else begin
                n_rot = op[1] ? ROT_270 : ROT_90;
            end
        end else if (u && size[0] && op == 4'd13) begin
            if (size == 2'd1) begin
                n_ad = {2'b10, q};
                n_aa = {2'b01, q};
                n_ab = {2'b01, q};
            end else begin
                n_ad = ARR_4S;
                n_aa = ARR_8H;
                n_ab = ARR_8H;
            end
        end else if (op == 4'd8) begin
            n_ad = ARR_4S;
            n_aa = ARR_16B;
            n_ab = ARR_16B;
        end else if (size == 2'd3 && op == 4'd15) begin
            n_ad = ARR_8H;
            n_aa = ARR_16B;
            n_ab = ARR_16B;
        end else if (op == 4'd13) begin
            if (size == 2'd0) begin
                n_ad = ARR_4H;
                n_aa = ARR_16B;
                n_ab = ARR_4S;
            end else begin
                n_ad = ARR_4S;
                n_aa = ARR_16B;
                n_ab = ARR_16B;
            end
        end else begin
            n_err = 1'b1;
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_ready) begin
            r_s1_valid <= i_valid;
        end
        if (s1_ready && i_valid) begin
            r_s1_word <= i_instruction_word;
        end
    end

    // Result register; an error clears every other field.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= r_s1_valid;
        end
        if (out_ready && r_s1_valid) begin
            r_err    <= n_err;
            r_id     <= n_err ? 5'd0 : hit.id;
            r_rd     <= n_err ? 5'd0 : r_s1_word[4:0];
            r_rn     <= n_err ? 5'd0 : r_s1_word[9:5];
            r_rm     <= n_err ? 5'd0 : r_s1_word[20:16];
            r_ad     <= n_err ? ARR_8B : n_ad;
            r_aa     <= n_err ? ARR_8B : n_aa;
            r_ab     <= n_err ? ARR_8B : n_ab;
            r_hasrot <= n_err ? 1'b0 : n_hasrot;
            r_rot    <= n_err ? ROT_0 : n_rot;
        end
    end

    assign o_valid             = r_out_valid;
    assign o_decode_error      = r_err;
    assign o_insn_id           = r_id;
    assign o_dest_index        = r_rd;
    assign o_src_a_index       = r_rn;
    assign o_src_b_index       = r_rm;
    assign o_dest_arrangement  = r_ad;
    assign o_src_a_arrangement = r_aa;
    assign o_src_b_arrangement = r_ab;
    assign o_has_rotation      = r_hasrot;
    assign o_rotation_degrees  = r_rot;

endmodule

// File: hw/rtl/s3rx_checker.sv
// Port-level checker for the SIMD three-register extension decoder.
// Depends on s3rx_pkg for rotation constants and the id range; bound to the top level.
module s3rx_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic [31:0] i_instruction_word,
    input logic        o_valid,
    input logic        i_ready,
    input logic        o_decode_error,
    input logic [4:0]  o_insn_id,
    input logic [4:0]  o_dest_index,
    input logic [4:0]  o_src_a_index,
    input logic [4:0]  o_src_b_index,
    input logic [2:0]  o_dest_arrangement,
    input logic [2:0]  o_src_a_arrangement,
    input logic [2:0]  o_src_b_arrangement,
    input logic        o_has_rotation,
    input logic [8:0]  o_rotation_degrees
);
    import s3rx_pkg::*;

    // A stalled result keeps its valid, error flag, id, destination index and rotation.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_decode_error)
            && $stable(o_insn_id) && $stable(o_dest_index)
            && $stable(o_rotation_degrees))
        else $error("result changed while stalled");

    // An error result has zero id, indices, destination arrangement and rotation.
    a_err_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_decode_error |-> o_insn_id == 5'd0 && o_dest_index == 5'd0
            && o_src_a_index == 5'd0 && o_src_b_index == 5'd0
            && o_dest_arrangement == 3'd0 && !o_has_rotation
            && o_rotation_degrees == ROT_0)
        else $error("error result has nonzero fields");

    // A good result has a known id and a consistent rotation.
    a_id_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_decode_error |-> o_insn_id <= ID_LAST
            && (o_has_rotation || o_rotation_degrees == ROT_0)
            && (o_rotation_degrees == ROT_0 || o_rotation_degrees == ROT_90
                || o_rotation_degrees == ROT_180 || o_rotation_degrees == ROT_270))
        else $error("bad id or rotation");

    // Rotation forms use one arrangement for all three operands.
    a_rot_same_arr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_decode_error && o_has_rotation |->
            o_dest_arrangement == o_src_a_arrangement
            && o_dest_arrangement == o_src_b_arrangement
            && o_dest_arrangement >= ARR_4H)
        else $error("rotation form with mixed arrangements");

endmodule

bind simd_three_reg_ext_decoder s3rx_checker u_s3rx_checker (.*);
